### rtl/core/pmr_pkg.sv
// Package: widths, base table and limits for the Miller-Rabin primality tester.
package pmr_pkg;
   localparam int NUMBER_WIDTH = 64;
   localparam int IDX_WIDTH = $clog2(NUMBER_WIDTH);
   localparam int BASE_COUNT_FULL = 12;
   localparam int BASE_COUNT_SMALL = 7;
   localparam logic [63:0] SMALL_LIMIT = 64'd341550071728321;

   function automatic logic [5:0] base_value(input logic [3:0] idx);
      logic [5:0] v;
      case (idx)
         4'd0: v = 6'd2;
         4'd1: v = 6'd3;
         4'd2: v = 6'd5;
         4'd3: v = 6'd7;
         4'd4: v = 6'd11;
         4'd5: v = 6'd13;
         4'd6: v = 6'd17;
         4'd7: v = 6'd19;
         4'd8: v = 6'd23;
         4'd9: v = 6'd29;
         4'd10: v = 6'd31;
         default: v = 6'd37;
      endcase
      return v;
   endfunction
endpackage

### rtl/core/pmr_mulmod.sv
// Shift-and-add modular multiplier, one bit of the multiplier per cycle.
module pmr_mulmod
   import pmr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] a,
   input  logic [NUMBER_WIDTH-1:0] b,
   input  logic [NUMBER_WIDTH-1:0] m,
   output logic                    done,
   output logic [NUMBER_WIDTH-1:0] result
);
   logic [NUMBER_WIDTH-1:0] a_ff, b_ff, m_ff, r_ff;
   logic [IDX_WIDTH-1:0]    bit_ff;
   logic                    run_ff, done_ff;
   logic [NUMBER_WIDTH:0]   dbl, dbl_red, add, add_red;
   logic [NUMBER_WIDTH-1:0] r_in;

   // double then conditionally add, both reduced by one subtract
   always_comb begin
      dbl = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      add = dbl_red + {1'b0, a_ff};
      add_red = (add >= {1'b0, m_ff}) ? add - {1'b0, m_ff} : add;
      r_in = b_ff[bit_ff] ? add_red[NUMBER_WIDTH-1:0] : dbl_red[NUMBER_WIDTH-1:0];
   end

   // load on start, then 64 bit steps; done pulses once the last step is in
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (bit_ff == '0) && !start;
         if (start) begin
            a_ff <= a;
            b_ff <= b;
            m_ff <= m;
            r_ff <= '0;
            bit_ff <= IDX_WIDTH'(NUMBER_WIDTH-1);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            r_ff <= r_in;
            bit_ff <= bit_ff - IDX_WIDTH'(1);
            run_ff <= (bit_ff != '0);
         end
      end
   end

   assign done = done_ff;
   assign result = r_ff;
endmodule

### rtl/core/primality_miller_rabin_64.sv
// Miller-Rabin primality tester: sequencer around a shared modular multiplier.
// Trivial values (below 2, 2, 3, even) go straight to the done state without the multiplier.
// A power step is a square only or a multiply and a square; a chain step is one squaring.
// One number at a time: busy stays high until the rsp_valid strobe.
// Reset (synchronous, active high) returns the sequencer to idle; no result.
module primality_miller_rabin_64
   import pmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_number,
   output logic        rsp_valid,
   output logic        rsp_prime
);
   typedef enum logic [3:0] {
      S_IDLE, S_SPLIT, S_BASE, S_POW_BIT, S_LAUNCH, S_WAIT, S_CHECK,
      S_CHAIN, S_CHAIN_CHK, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ACC, OP_SQ, OP_CHAIN
   } op_type;

   state_type               state_ff;
   op_type                  op_ff;
   logic [NUMBER_WIDTH-1:0] n_ff, d_ff, e_ff, acc_ff, sq_ff;
   logic [IDX_WIDTH-1:0]    r_ff, j_ff;
   logic [3:0]              base_ff, count_ff;
   logic                    prime_ff, valid_ff, busy_ff;
   logic                    mm_start;
   logic [NUMBER_WIDTH-1:0] mm_a, mm_b, mm_res;
   logic                    mm_done;
   logic [NUMBER_WIDTH-1:0] n_in, nm1;

   assign n_in = req_number[NUMBER_WIDTH-1:0];
   assign nm1 = n_ff - NUMBER_WIDTH'(1);

   pmr_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mm_start), .a(mm_a), .b(mm_b),
      .m(n_ff), .done(mm_done), .result(mm_res)
   );

   // operand select for the shared multiplier
   always_comb begin
      mm_start = (state_ff == S_LAUNCH);
      case (op_ff)
         OP_ACC: begin
            mm_a = acc_ff; mm_b = sq_ff;
         end
         OP_CHAIN: begin
            mm_a = acc_ff; mm_b = acc_ff;
         end
         default: begin
            mm_a = sq_ff; mm_b = sq_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= (state_ff == S_DONE);
         unique case (state_ff)
            S_IDLE: if (start) begin
               n_ff <= n_in;
               busy_ff <= 1'b1;
               if (n_in < NUMBER_WIDTH'(2)) begin
                  prime_ff <= 1'b0; state_ff <= S_DONE;
               end else if (n_in < NUMBER_WIDTH'(4)) begin
                  prime_ff <= 1'b1; state_ff <= S_DONE;
               end else if (!n_in[0]) begin
                  prime_ff <= 1'b0; state_ff <= S_DONE;
               end else begin
                  d_ff <= n_in - NUMBER_WIDTH'(1);
                  r_ff <= '0;
                  base_ff <= '0;
                  prime_ff <= 1'b1;
                  count_ff <= (64'(n_in) < SMALL_LIMIT)
                     ? 4'(BASE_COUNT_SMALL) : 4'(BASE_COUNT_FULL);
                  state_ff <= S_SPLIT;
               end
            end
            // strip trailing zeros, one per cycle
            S_SPLIT: if (!d_ff[0]) begin
               d_ff <= d_ff >> 1;
               r_ff <= r_ff + IDX_WIDTH'(1);
            end else state_ff <= S_BASE;
            // next base, or finished once the bases run out or reach n
            S_BASE:
               if (base_ff == count_ff ||
                   NUMBER_WIDTH'(base_value(base_ff)) >= n_ff) state_ff <= S_DONE;
               else begin
                  acc_ff <= NUMBER_WIDTH'(1);
                  sq_ff <= NUMBER_WIDTH'(base_value(base_ff));
                  e_ff <= d_ff;
                  state_ff <= S_POW_BIT;
               end
            // power loop: multiply when the bit is set, then square
            S_POW_BIT:
               if (e_ff == '0) state_ff <= S_CHECK;
               else begin
                  op_ff <= e_ff[0] ? OP_ACC : OP_SQ;
                  state_ff <= S_LAUNCH;
               end
            S_LAUNCH: state_ff <= S_WAIT;
            S_WAIT: if (mm_done) begin
               case (op_ff)
                  OP_ACC: begin
                     acc_ff <= mm_res; op_ff <= OP_SQ; state_ff <= S_LAUNCH;
                  end
                  OP_SQ: begin
                     sq_ff <= mm_res; e_ff <= e_ff >> 1; state_ff <= S_POW_BIT;
                  end
                  default: begin
                     acc_ff <= mm_res; state_ff <= S_CHAIN_CHK;
                  end
               endcase
            end
            S_CHECK:
               if (acc_ff == NUMBER_WIDTH'(1) || acc_ff == nm1) begin
                  base_ff <= base_ff + 4'd1; state_ff <= S_BASE;
               end else begin
                  j_ff <= IDX_WIDTH'(1); state_ff <= S_CHAIN;
               end
            // squaring chain: up to r-1 squarings looking for n-1
            S_CHAIN:
               if (j_ff < r_ff) begin
                  op_ff <= OP_CHAIN; state_ff <= S_LAUNCH;
               end else begin
                  prime_ff <= 1'b0; state_ff <= S_DONE;
               end
            S_CHAIN_CHK:
               if (acc_ff == nm1) begin
                  base_ff <= base_ff + 4'd1; state_ff <= S_BASE;
               end else begin
                  j_ff <= j_ff + IDX_WIDTH'(1); state_ff <= S_CHAIN;
               end
            S_DONE: begin
               busy_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = busy_ff;
   assign rsp_valid = valid_ff;
   assign rsp_prime = prime_ff;
endmodule

### rtl/core/pmr_checker.sv
// Port-level checker for the primality tester, bound to the top level.
module pmr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_valid_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("strobe too long");
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid) else $error("busy fell without result");
endmodule

bind primality_miller_rabin_64 pmr_checker u_pmr_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .rsp_valid(rsp_valid)
);

### tb/sv/tb.sv
// Testbench for the 64-bit Miller-Rabin primality tester: table, random numbers, scoreboard.
module tb;
   import pmr_pkg::*;

   localparam int CYCLE_LIMIT = 40_000_000;
   localparam int TAIL_CYCLES = 16;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_number;
   logic        rsp_valid;
   logic        rsp_prime;

   // directed row: number, and an expectation only where it is obvious
   typedef struct {
      logic [63:0] number;
      logic        typed;
      logic        prime;
   } number_row_type;

   bit     prime_expected_q[$];
   int     mismatch_count;
   int     cycle_count;
   int     idle_pct;

   primality_miller_rabin_64 dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_number   (req_number),
      .rsp_valid    (rsp_valid),
      .rsp_prime    (rsp_prime)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // (a * b) mod m through a full 128-bit product
   function automatic logic [63:0] mulmod_128(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod % {64'd0, m});
   endfunction

   function automatic logic [63:0] powmod_64(logic [63:0] a, logic [63:0] e, logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 64'd1;
      sq  = a % m;
      while (e != 64'd0) begin
         if (e[0]) acc = mulmod_128(acc, sq, m);
         sq = mulmod_128(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   // deterministic witness test over the fixed prime bases
   function automatic bit primality_of(logic [63:0] raw);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] x;
      logic [63:0] a;
      int          r;
      int          nbases;
      bit          passed;
      n = raw & ({64{1'b1}} >> (64 - NUMBER_WIDTH));
      if (n < 64'd2) return 1'b0;
      if (n == 64'd2 || n == 64'd3) return 1'b1;
      if (!n[0]) return 1'b0;
      d = n - 64'd1;
      r = 0;
      while (!d[0]) begin
         d = d >> 1;
         r++;
      end
      nbases = (n < SMALL_LIMIT) ? BASE_COUNT_SMALL : BASE_COUNT_FULL;
      for (int i = 0; i < nbases; i++) begin
         a = (i == 0) ? 64'd2 : (i == 1) ? 64'd3 : (i == 2) ? 64'd5 : (i == 3) ? 64'd7 :
             (i == 4) ? 64'd11 : (i == 5) ? 64'd13 : (i == 6) ? 64'd17 :
             (i == 7) ? 64'd19 : (i == 8) ? 64'd23 : (i == 9) ? 64'd29 :
             (i == 10) ? 64'd31 : 64'd37;
         if (a >= n) break;
         x = powmod_64(a, d, n);
         if (x == 64'd1 || x == n - 64'd1) continue;
         passed = 1'b0;
         for (int j = 1; j < r; j++) begin
            x = mulmod_128(x, x, n);
            if (x == n - 64'd1) begin
               passed = 1'b1;
               break;
            end
         end
         if (!passed) return 1'b0;
      end
      return 1'b1;
   endfunction

   // drive one beat and hold it until the block takes it
   task automatic send_number(logic [63:0] number, bit expected);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_number <= number;
      forever begin
         @(posedge clock);
         if (start && !busy) break;
      end
      prime_expected_q.push_back(expected);
      @(negedge clock);
      start      <= 1'b0;
      req_number <= {$urandom, $urandom};
   endtask

   // mostly small odd values so that the run stays short; a few full-width
   function automatic logic [63:0] random_number();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return {48'd0, 16'($urandom) | 16'd1};
      if (pick < 75) return {$urandom, $urandom};
      if (pick < 90) return {24'd0, 40'({$urandom, $urandom}) | 40'd1};
      if (pick < 95) return {$urandom, $urandom | 32'd1};
      return {$urandom, $urandom} & ~64'd1;
   endfunction

   // result checker
   always @(posedge clock) begin
      bit expected;
      if (!reset && rsp_valid) begin
         if (prime_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: prime=%0b", rsp_prime);
         end else begin
            expected = prime_expected_q.pop_front();
            if (rsp_prime !== expected) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("prime mismatch: expected %0b actual %0b", expected,
                           rsp_prime);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      number_row_type rows[$];
      logic [63:0] n;
      start          = 1'b0;
      req_number     = 64'd0;
      reset          = 1'b1;
      mismatch_count = 0;
      cycle_count    = 0;
      idle_pct       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table: trivial values, extremes, small-base cut-off, pseudoprimes
      rows = '{
         '{64'd0, 1'b1, 1'b0},
         '{64'd1, 1'b1, 1'b0},
         '{64'd2, 1'b1, 1'b1},
         '{64'd3, 1'b1, 1'b1},
         '{64'd4, 1'b1, 1'b0},
         '{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},
         '{64'd5, 1'b1, 1'b1},
         '{64'd7, 1'b1, 1'b1},
         '{64'd9, 1'b1, 1'b0},
         '{64'd17, 1'b1, 1'b1},
         '{64'd19, 1'b1, 1'b1},
         '{64'd37, 1'b1, 1'b1},
         '{64'd41, 1'b0, 1'b0},
         '{64'd341, 1'b0, 1'b0},
         '{64'd561, 1'b0, 1'b0},
         '{64'd2047, 1'b0, 1'b0},
         '{64'd3215031751, 1'b0, 1'b0},
         '{SMALL_LIMIT, 1'b0, 1'b0},
         '{SMALL_LIMIT - 64'd2, 1'b0, 1'b0},
         '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
         '{64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 1'b0},
         '{64'h8000_0000_0000_0001, 1'b0, 1'b0}
      };
      foreach (rows[i])
         send_number(rows[i].number,
                     rows[i].typed ? rows[i].prime : primality_of(rows[i].number));

      // random part in idling phases: none, half, eleven percent
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 1) ? 50 : (phase == 2) ? 11 : 0;
         for (int k = 0; k < 26; k++) begin
            n = random_number();
            send_number(n, primality_of(n));
         end
      end

      while (prime_expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
